// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the RTL controller. They expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked on every rising edge while reset is released.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The expression must never be true while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/core/cfcr_pkg.sv -----
package cfcr_pkg;

  localparam int FRACTION_BITS = 24;
  localparam int TABLE_LEN     = 17;
  localparam int IDX_W         = 5;

  localparam logic [IDX_W-1:0] LONG_START  = IDX_W'(16);
  localparam logic [IDX_W-1:0] SHORT_START = IDX_W'(4);

  localparam logic [FRACTION_BITS-1:0] CARRY_START = FRACTION_BITS'(362436);
  localparam logic [FRACTION_BITS-1:0] CARRY_STEP  = FRACTION_BITS'(7654321);
  // Wrap modulus minus the step, added when the carry would go below zero.
  localparam logic [FRACTION_BITS-1:0] CARRY_WRAP  = FRACTION_BITS'(16777213 - 7654321);

  // Seed remainder moduli and the mixing recurrence constants.
  localparam logic [7:0] SEED_MOD_A = 8'd177;
  localparam logic [7:0] SEED_MOD_B = 8'd167;
  localparam logic [7:0] SEED_MOD_C = 8'd157;
  localparam logic [7:0] SEED_MOD_D = 8'd147;
  localparam int         MIX_MOD    = 179;
  localparam int         LCG_MOD    = 169;
  localparam logic [13:0] LCG_MUL   = 14'd53;
  localparam logic [13:0] LCG_ADD   = 14'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW_WR,
    ST_SEED_MOD,
    ST_SEED_INIT,
    ST_MIX_MUL1,
    ST_MIX_RED1,
    ST_MIX_MUL2,
    ST_MIX_RED2
  } state_t;

  typedef struct packed {
    logic load_seed;
    logic mod_step;
    logic seed_init;
    logic mix_mul1;
    logic mix_red1;
    logic mix_mul2;
    logic mix_red2;
    logic draw_rd;
    logic draw_commit;
  } cmd_t;

  typedef struct packed {
    logic mod_last;
    logic seed_last;
  } sts_t;

  // Power-on contents of the lag table.
  function automatic logic [FRACTION_BITS-1:0] reset_entry(input logic [IDX_W-1:0] idx);
    logic [FRACTION_BITS-1:0] v;
    case (idx)
      5'd0:    v = 24'd14543620;
      5'd1:    v = 24'd6204192;
      5'd2:    v = 24'd13436819;
      5'd3:    v = 24'd7002625;
      5'd4:    v = 24'd13848856;
      5'd5:    v = 24'd16174856;
      5'd6:    v = 24'd7564289;
      5'd7:    v = 24'd10823501;
      5'd8:    v = 24'd2760617;
      5'd9:    v = 24'd4677323;
      5'd10:   v = 24'd1134397;
      5'd11:   v = 24'd16212204;
      5'd12:   v = 24'd329394;
      5'd13:   v = 24'd494491;
      5'd14:   v = 24'd2745141;
      5'd15:   v = 24'd6671197;
      5'd16:   v = 24'd4414100;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] v;
    if (idx == '0) begin
      v = IDX_W'(TABLE_LEN - 1);
    end else begin
      v = idx - IDX_W'(1);
    end
    return v;
  endfunction

  // Folds one byte into a remainder below m by shifted compare and subtract.
  function automatic logic [7:0] rem_byte(input logic [7:0] r, input logic [7:0] b,
                                          input logic [7:0] m);
    logic [15:0] v;
    logic [15:0] s;
    v = {r, b};
    for (int k = 7; k >= 0; k--) begin
      s = 16'(m) << k;
      if (v >= s) begin
        v = v - s;
      end
    end
    return v[7:0];
  endfunction

  // Reduces a product of two values below 179 by shifted compare and subtract.
  function automatic logic [7:0] mod179(input logic [14:0] x);
    logic [14:0] v;
    logic [14:0] s;
    v = x;
    for (int k = 7; k >= 0; k--) begin
      s = 15'(MIX_MOD) << k;
      if (v >= s) begin
        v = v - s;
      end
    end
    return v[7:0];
  endfunction

  // Same reduction for the 53*d+1 recurrence, whose value stays below 169*64.
  function automatic logic [7:0] mod169(input logic [13:0] x);
    logic [13:0] v;
    logic [13:0] s;
    v = x;
    for (int k = 5; k >= 0; k--) begin
      s = 14'(LCG_MOD) << k;
      if (v >= s) begin
        v = v - s;
      end
    end
    return v[7:0];
  endfunction

endpackage

// ----- rtl/core/combined_fibonacci_congruential_rng.sv -----
// Channel  Ports                       Handshake           Beat
// input    in_kind, in_seed            in_valid/in_stall   one draw or one reseed request
// output   out_value                   out_valid/out_stall one 24-bit fraction per draw
//
// In a draw, the two lag taps are read into registers, then the difference is
// written back and the result register is loaded.
// A reseed, after its beat, folds the seed magnitude into its remainders a byte
// at a time, loads the mixer, then runs 408 bits through the mixer states
// MIX_MUL1, MIX_RED1, MIX_MUL2 and MIX_RED2, one bit per pass.
// A draw waits in its write cycle while the output register holds an untaken beat.
// Synchronous reset restores the power-on table, both indices and the carry.
module combined_fibonacci_congruential_rng #(
  parameter int FRACTION_BITS = cfcr_pkg::FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic signed [31:0]       in_seed,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [FRACTION_BITS-1:0] out_value
);

  cfcr_pkg::cmd_t cmd;
  cfcr_pkg::sts_t sts;

  cfcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  cfcr_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_seed   (in_seed),
    .cmd       (cmd),
    .sts       (sts),
    .out_value (out_value)
  );

endmodule

// ----- rtl/core/cfcr_datapath.sv -----
module cfcr_datapath #(
  parameter int FRACTION_BITS = cfcr_pkg::FRACTION_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [31:0]              in_seed,
  input  cfcr_pkg::cmd_t           cmd,
  output cfcr_pkg::sts_t           sts,
  output logic [FRACTION_BITS-1:0] out_value
);

  localparam int TL  = cfcr_pkg::TABLE_LEN;
  localparam int IW  = cfcr_pkg::IDX_W;
  localparam int BCW = $clog2(FRACTION_BITS);
  localparam logic [BCW-1:0] BIT_LAST = BCW'(FRACTION_BITS - 1);
  localparam logic [IW-1:0]  ENT_LAST = IW'(TL - 1);

  localparam logic [FRACTION_BITS-1:0] CARRY_START = FRACTION_BITS'(cfcr_pkg::CARRY_START);
  localparam logic [FRACTION_BITS-1:0] CARRY_STEP  = FRACTION_BITS'(cfcr_pkg::CARRY_STEP);
  localparam logic [FRACTION_BITS-1:0] CARRY_WRAP  = FRACTION_BITS'(cfcr_pkg::CARRY_WRAP);

  logic [FRACTION_BITS-1:0] mem [TL];
  logic [TL-1:0]            valid_r;

  logic [IW-1:0]            li_r;
  logic [IW-1:0]            si_r;
  logic [FRACTION_BITS-1:0] carry_r;
  logic [FRACTION_BITS-1:0] carry_nxt;
  logic [FRACTION_BITS-1:0] rd_l_r;
  logic [FRACTION_BITS-1:0] rd_s_r;
  logic [FRACTION_BITS-1:0] value_r;
  logic [FRACTION_BITS-1:0] fib;

  logic [31:0]              mag_r;
  logic [31:0]              mag_nxt;
  logic [1:0]               mod_cnt_r;
  logic [7:0]               ra_r, rb_r, rc_r, rd_r;
  logic [7:0]               a_r, b_r, c_r, d_r;
  logic [14:0]              prod_r;
  logic [7:0]               red_r;
  logic [13:0]              dprod_r;
  logic [FRACTION_BITS-2:0] acc_r;
  logic [BCW-1:0]           bit_cnt_r;
  logic [IW-1:0]            ent_cnt_r;

  logic [7:0]               n_val;
  logic [5:0]               dn_prod;
  logic                     nbit;
  logic                     seed_we;
  logic                     mem_we;
  logic [IW-1:0]            mem_waddr;
  logic [FRACTION_BITS-1:0] mem_wdata;

  assign fib       = rd_l_r - rd_s_r;
  assign carry_nxt = (carry_r >= CARRY_STEP) ? (carry_r - CARRY_STEP) : (carry_r + CARRY_WRAP);
  assign mag_nxt   = in_seed[31] ? (32'd0 - in_seed) : in_seed;

  assign n_val   = cfcr_pkg::mod179(prod_r);
  // Only the low six bits of d*n decide the output bit.
  assign dn_prod = d_r[5:0] * n_val[5:0];
  assign nbit    = dn_prod[5];

  assign seed_we   = cmd.mix_red2 && (bit_cnt_r == BIT_LAST);
  assign mem_we    = cmd.draw_commit || seed_we;
  assign mem_waddr = cmd.draw_commit ? li_r : ent_cnt_r;
  assign mem_wdata = cmd.draw_commit ? fib : {acc_r, nbit};

  assign sts.mod_last  = &mod_cnt_r;
  assign sts.seed_last = (bit_cnt_r == BIT_LAST) && (ent_cnt_r == ENT_LAST);
  assign out_value     = value_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // An entry that was never written since reset reads as its power-on constant.
  always_ff @(posedge clk) begin
    if (cmd.draw_rd) begin
      rd_l_r <= valid_r[li_r] ? mem[li_r] : FRACTION_BITS'(cfcr_pkg::reset_entry(li_r));
      rd_s_r <= valid_r[si_r] ? mem[si_r] : FRACTION_BITS'(cfcr_pkg::reset_entry(si_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      li_r      <= cfcr_pkg::LONG_START;
      si_r      <= cfcr_pkg::SHORT_START;
      carry_r   <= CARRY_START;
      mod_cnt_r <= '0;
      bit_cnt_r <= '0;
      ent_cnt_r <= '0;
    end else begin
      if (mem_we) begin
        valid_r[mem_waddr] <= 1'b1;
      end
      if (cmd.draw_commit) begin
        li_r    <= cfcr_pkg::step_down(li_r);
        si_r    <= cfcr_pkg::step_down(si_r);
        carry_r <= carry_nxt;
      end else if (seed_we && sts.seed_last) begin
        li_r    <= cfcr_pkg::LONG_START;
        si_r    <= cfcr_pkg::SHORT_START;
        carry_r <= CARRY_START;
      end
      if (cmd.load_seed) begin
        mod_cnt_r <= '0;
      end else if (cmd.mod_step) begin
        mod_cnt_r <= mod_cnt_r + 2'd1;
      end
      if (cmd.seed_init) begin
        bit_cnt_r <= '0;
        ent_cnt_r <= '0;
      end else if (cmd.mix_red2) begin
        if (bit_cnt_r == BIT_LAST) begin
          bit_cnt_r <= '0;
          ent_cnt_r <= ent_cnt_r + IW'(1);
        end else begin
          bit_cnt_r <= bit_cnt_r + BCW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_commit) begin
      value_r <= fib - carry_nxt;
    end
    // The magnitude is folded in a byte at a time, most significant byte first,
    // into four remainders.
    if (cmd.load_seed) begin
      mag_r <= mag_nxt;
      ra_r  <= '0;
      rb_r  <= '0;
      rc_r  <= '0;
      rd_r  <= '0;
    end else if (cmd.mod_step) begin
      mag_r <= {mag_r[23:0], 8'd0};
      ra_r  <= cfcr_pkg::rem_byte(ra_r, mag_r[31:24], cfcr_pkg::SEED_MOD_A);
      rb_r  <= cfcr_pkg::rem_byte(rb_r, mag_r[31:24], cfcr_pkg::SEED_MOD_B);
      rc_r  <= cfcr_pkg::rem_byte(rc_r, mag_r[31:24], cfcr_pkg::SEED_MOD_C);
      rd_r  <= cfcr_pkg::rem_byte(rd_r, mag_r[31:24], cfcr_pkg::SEED_MOD_D);
    end
    if (cmd.seed_init) begin
      a_r <= ra_r + 8'd1;
      b_r <= rb_r + 8'd1;
      c_r <= rc_r + 8'd1;
      d_r <= rd_r + 8'd1;
    end else if (cmd.mix_red1) begin
      d_r <= cfcr_pkg::mod169(dprod_r);
    end else if (cmd.mix_red2) begin
      a_r <= b_r;
      b_r <= c_r;
      c_r <= n_val;
    end
    if (cmd.mix_mul1) begin
      prod_r  <= 15'(a_r) * 15'(b_r);
      dprod_r <= 14'(d_r) * cfcr_pkg::LCG_MUL + cfcr_pkg::LCG_ADD;
    end else if (cmd.mix_mul2) begin
      prod_r <= 15'(red_r) * 15'(c_r);
    end
    if (cmd.mix_red1) begin
      red_r <= cfcr_pkg::mod179(prod_r);
    end
    if (cmd.mix_red2) begin
      acc_r <= {acc_r[FRACTION_BITS-3:0], nbit};
    end
  end

endmodule

// ----- rtl/core/cfcr_ctrl.sv -----
`include "assert_macros.svh"

module cfcr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_kind,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output cfcr_pkg::cmd_t cmd,
  input  cfcr_pkg::sts_t sts
);

  cfcr_pkg::state_t state_r;
  cfcr_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_free;

  // The output register can take a new beat if it is empty or is being taken now.
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfcr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.draw_commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      cfcr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_kind) begin
            cmd.load_seed = 1'b1;
            state_nxt     = cfcr_pkg::ST_SEED_MOD;
          end else begin
            cmd.draw_rd = 1'b1;
            state_nxt   = cfcr_pkg::ST_DRAW_WR;
          end
        end
      end
      cfcr_pkg::ST_DRAW_WR: begin
        if (out_free) begin
          cmd.draw_commit = 1'b1;
          state_nxt       = cfcr_pkg::ST_IDLE;
        end
      end
      cfcr_pkg::ST_SEED_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = cfcr_pkg::ST_SEED_INIT;
        end
      end
      cfcr_pkg::ST_SEED_INIT: begin
        cmd.seed_init = 1'b1;
        state_nxt     = cfcr_pkg::ST_MIX_MUL1;
      end
      cfcr_pkg::ST_MIX_MUL1: begin
        cmd.mix_mul1 = 1'b1;
        state_nxt    = cfcr_pkg::ST_MIX_RED1;
      end
      cfcr_pkg::ST_MIX_RED1: begin
        cmd.mix_red1 = 1'b1;
        state_nxt    = cfcr_pkg::ST_MIX_MUL2;
      end
      cfcr_pkg::ST_MIX_MUL2: begin
        cmd.mix_mul2 = 1'b1;
        state_nxt    = cfcr_pkg::ST_MIX_RED2;
      end
      cfcr_pkg::ST_MIX_RED2: begin
        cmd.mix_red2 = 1'b1;
        state_nxt    = sts.seed_last ? cfcr_pkg::ST_IDLE : cfcr_pkg::ST_MIX_MUL1;
      end
      default: begin
        state_nxt = cfcr_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_RST(a_commit_free, clk, rst_n, cmd.draw_commit |-> out_free, "commit into a full output")
  `ASSERT_RST(a_commit_shows, clk, rst_n, cmd.draw_commit |=> out_valid_r, "committed draw not shown")
  `ASSERT_RST(a_draw_path, clk, rst_n, cmd.draw_rd |=> (state_r == cfcr_pkg::ST_DRAW_WR), "draw lost")
  `ASSERT_RST(a_mod_done, clk, rst_n, (cmd.mod_step && sts.mod_last) |=> cmd.seed_init, "seed init skipped")
  `ASSERT_NEVER(a_one_cmd, clk, rst_n, cmd.draw_commit && (cmd.mix_red2 || cmd.load_seed), "commands overlap")

endmodule

// ----- verif/tb_combined_fibonacci_congruential_rng.sv -----
`timescale 1ns / 1ps

module tb_combined_fibonacci_congruential_rng;

  localparam int FRACTION_BITS = cfcr_pkg::FRACTION_BITS;
  localparam int TABLE_LEN     = cfcr_pkg::TABLE_LEN;
  localparam int IDX_W         = cfcr_pkg::IDX_W;

  localparam logic [IDX_W-1:0]         LONG_START  = cfcr_pkg::LONG_START;
  localparam logic [IDX_W-1:0]         SHORT_START = cfcr_pkg::SHORT_START;
  localparam logic [FRACTION_BITS-1:0] CARRY_START = cfcr_pkg::CARRY_START;
  localparam logic [FRACTION_BITS-1:0] CARRY_STEP  = cfcr_pkg::CARRY_STEP;
  localparam logic [FRACTION_BITS-1:0] CARRY_WRAP  = cfcr_pkg::CARRY_WRAP;

  localparam int WATCHDOG_LIMIT = 20000;
  // The drain is long enough to cover a reseed that runs after its beat.
  localparam int DRAIN_CYCLES   = 1800;
  localparam int RANDOM_ITEMS   = 2000;

  typedef struct packed {
    logic        kind;
    logic [31:0] seed;
    logic        wait_empty;
  } rng_req_t;

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  localparam logic [FRACTION_BITS-1:0] POWER_ON_LAGS [TABLE_LEN] = '{
    24'd14543620, 24'd6204192, 24'd13436819, 24'd7002625, 24'd13848856, 24'd16174856,
    24'd7564289, 24'd10823501, 24'd2760617, 24'd4677323, 24'd1134397, 24'd16212204,
    24'd329394, 24'd494491, 24'd2745141, 24'd6671197, 24'd4414100
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_kind = KIND_DRAW;
  logic signed [31:0]       in_seed = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [FRACTION_BITS-1:0] out_value;

  combined_fibonacci_congruential_rng dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .in_seed  (in_seed),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Generator state as the predictor sees it.
  logic [FRACTION_BITS-1:0] lag_mem [TABLE_LEN];
  logic [IDX_W-1:0]         tap_long;
  logic [IDX_W-1:0]         tap_short;
  logic [FRACTION_BITS-1:0] carry_reg;

  rng_req_t                 pending_reqs[$];
  logic [FRACTION_BITS-1:0] expected_fractions[$];

  int  mismatches = 0;
  int  n_accepted = 0;
  int  idle_cycles = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;

  int  burst_left = 0;
  int  gap_left = 0;
  int  seg_left = 0;
  int  seg_mode = 0;
  int  holdoff_left = 0;
  int  next_holdoff_at = 300;
  rng_req_t next_req;
  logic [FRACTION_BITS-1:0] front_fraction;

  task automatic restore_power_on();
    for (int i = 0; i < TABLE_LEN; i++) begin
      lag_mem[i] = POWER_ON_LAGS[i];
    end
    tap_long  = LONG_START;
    tap_short = SHORT_START;
    carry_reg = CARRY_START;
  endtask

  task automatic reload_table(input logic [31:0] raw);
    int unsigned mag;
    int unsigned a, b, c, d, n;
    logic [FRACTION_BITS-1:0] acc;
    mag = raw[31] ? (32'd0 - raw) : raw;
    a = (mag % 177) + 1;
    b = (mag % 167) + 1;
    c = (mag % 157) + 1;
    d = (mag % 147) + 1;
    for (int e = 0; e < TABLE_LEN; e++) begin
      acc = '0;
      for (int k = FRACTION_BITS - 1; k >= 0; k--) begin
        n = (((a * b) % 179) * c) % 179;
        a = b;
        b = c;
        c = n;
        d = (53 * d + 1) % 169;
        if (((d * n) % 64) >= 32) begin
          acc[k] = 1'b1;
        end
      end
      lag_mem[e] = acc;
    end
    tap_long  = LONG_START;
    tap_short = SHORT_START;
    carry_reg = CARRY_START;
  endtask

  function automatic logic [FRACTION_BITS-1:0] predict_draw();
    logic [FRACTION_BITS-1:0] fib;
    fib = lag_mem[tap_long] - lag_mem[tap_short];
    lag_mem[tap_long] = fib;
    tap_long  = (tap_long == 0) ? IDX_W'(TABLE_LEN - 1) : tap_long - 1'b1;
    tap_short = (tap_short == 0) ? IDX_W'(TABLE_LEN - 1) : tap_short - 1'b1;
    if (carry_reg >= CARRY_STEP) begin
      carry_reg = carry_reg - CARRY_STEP;
    end else begin
      carry_reg = carry_reg + CARRY_WRAP;
    end
    return fib - carry_reg;
  endfunction

  task automatic report_mismatch(input string what, input logic [FRACTION_BITS-1:0] got,
                                 input logic [FRACTION_BITS-1:0] want);
    $display("mismatch at %0t: %s, got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic queue_req(input logic kind, input logic [31:0] seed, input logic hold);
    rng_req_t r;
    r.kind = kind;
    r.seed = seed;
    r.wait_empty = hold;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] random_seed();
    logic [31:0] s;
    case ($urandom_range(0, 3))
      0: s = $urandom_range(0, 1000);
      1: s = 32'd0 - $urandom_range(1, 1000);
      default: s = $urandom;
    endcase
    return s;
  endfunction

  // Sender: beats change on the falling edge, in bursts that are mostly separated by gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_kind  <= KIND_DRAW;
      in_seed  <= '0;
    end else if (in_valid && !in_taken) begin
      // Stalled beat stays as it is.
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_reqs.size() != 0 &&
                 !(pending_reqs[0].wait_empty && expected_fractions.size() != 0)) begin
      next_req = pending_reqs.pop_front();
      in_valid <= 1'b1;
      in_kind  <= next_req.kind;
      in_seed  <= next_req.seed;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 60);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      end else begin
        burst_left--;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall pattern in segments, plus a long hold-off now and then.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (n_accepted >= next_holdoff_at) begin
        next_holdoff_at += 900;
        holdoff_left = 600;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(5, 80);
        end
        seg_left--;
        case (seg_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Monitor: results are checked before the beat of this edge is predicted,
  // since a result always belongs to an older draw.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken  = 1'b0;
      out_taken = 1'b0;
    end else begin
      out_taken = out_valid && !out_stall;
      in_taken  = in_valid && !in_stall;
      if (out_taken) begin
        if (expected_fractions.size() == 0) begin
          report_mismatch("result with no draw waiting", out_value, '0);
        end else begin
          front_fraction = expected_fractions.pop_front();
          if (out_value !== front_fraction) begin
            report_mismatch("value", out_value, front_fraction);
          end
        end
      end
      if (in_taken) begin
        n_accepted++;
        if (in_kind == KIND_RESEED) begin
          reload_table(in_seed);
        end else begin
          expected_fractions.push_back(predict_draw());
        end
      end
      if (in_taken || out_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    restore_power_on();

    // Directed part: power-on draws, then reseeds at the seed extremes.
    queue_req(KIND_DRAW, 32'h0000_0000, 1'b0);
    queue_req(KIND_DRAW, 32'hFFFF_FFFF, 1'b0);
    queue_req(KIND_DRAW, 32'h8000_0000, 1'b0);
    queue_req(KIND_RESEED, 32'h0000_0000, 1'b0);
    queue_req(KIND_DRAW, 32'h7FFF_FFFF, 1'b0);
    queue_req(KIND_DRAW, 32'h0000_0000, 1'b0);
    queue_req(KIND_RESEED, 32'h8000_0000, 1'b1);
    queue_req(KIND_DRAW, 32'h0000_0000, 1'b0);
    queue_req(KIND_RESEED, 32'h7FFF_FFFF, 1'b0);
    queue_req(KIND_DRAW, 32'h0000_0000, 1'b0);
    queue_req(KIND_RESEED, 32'hFFFF_FFFF, 1'b0);
    queue_req(KIND_DRAW, 32'h0000_0000, 1'b0);
    queue_req(KIND_RESEED, 32'h0000_0001, 1'b0);
    queue_req(KIND_DRAW, 32'h0000_0000, 1'b0);
    queue_req(KIND_RESEED, 32'h8000_0001, 1'b0);
    for (int i = 0; i < 6; i++) begin
      queue_req(KIND_DRAW, $urandom, 1'b0);
    end

    // Random part: mostly draws, so the taps wrap many times between reseeds.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 59) == 0) begin
        queue_req(KIND_RESEED, random_seed(), 1'b0);
      end else begin
        queue_req(KIND_DRAW, $urandom, ($urandom_range(0, 199) == 0));
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (expected_fractions.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_fractions.size() != 0) begin
      report_mismatch("draw left without a result", '0, expected_fractions[0]);
    end

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
